@@ hw/rtl/tcgle_pkg.sv @@
// Package for the text console grid line editor.
// Holds the mode and character constants and the controller to datapath command and status types.
// It has no dependencies.
package tcgle_pkg;

  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_PRINT = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SEL_ITEM   = 2'd0,
    SEL_DOLLAR = 2'd1,
    SEL_SPACE  = 2'd2
  } char_sel_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [1:0] PROMPT_NONE   = 2'd0;
  localparam logic [1:0] PROMPT_SPACE  = 2'd1;
  localparam logic [1:0] PROMPT_DOLLAR = 2'd2;

  typedef struct packed {
    logic      latch;
    logic      count_clear;
    logic      count_inc;
    logic      place;
    char_sel_t char_sel;
    logic      newline;
    logic      sweep_clr;
    logic      scroll_wr;
    logic      fill_wr;
    logic      home;
    logic      back;
    logic      blank;
    logic      read;
    logic      capture;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic ch_line_end;
    logic ch_lf;
    logic ch_bs;
    logic count_zero;
    logic count_full;
    logic col_wrap;
    logic row_bottom;
    logic row_done;
    logic fill_done;
  } dp_status_t;

endpackage

@@ hw/rtl/tcgle_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// It has no dependencies.
module tcgle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 480
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tcgle_ctrl.sv @@
// Controller state machine of the text console grid line editor.
// Sequences each request into datapath commands; depends on tcgle_pkg.
module tcgle_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tcgle_pkg::mode_t       mode,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  tcgle_pkg::dp_status_t  st,
  output tcgle_pkg::dp_cmd_t     cmd
);
  import tcgle_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_PLACE   = 10'b00_0000_0010,
    S_NEWLINE = 10'b00_0000_0100,
    S_SCROLL  = 10'b00_0000_1000,
    S_BACK    = 10'b00_0001_0000,
    S_BLANK   = 10'b00_0010_0000,
    S_READ    = 10'b00_0100_0000,
    S_READW   = 10'b00_1000_0000,
    S_CLEAR   = 10'b01_0000_0000,
    S_FINISH  = 10'b10_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] prompt, prompt_next, prompt_dec;
  logic       from_item, from_item_next;
  logic       out_valid_next;

  assign in_ready   = (state == S_IDLE);
  assign prompt_dec = (prompt == PROMPT_NONE) ? PROMPT_NONE : prompt - 2'd1;

  always_comb begin
    state_next     = state;
    prompt_next    = prompt;
    from_item_next = from_item;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.char_sel   = SEL_ITEM;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (mode)
            MODE_KEY: begin
              if (st.ch_line_end) begin
                cmd.count_clear = 1'b1;
                prompt_next     = PROMPT_DOLLAR;
                state_next      = S_NEWLINE;
              end else if (st.ch_bs) begin
                state_next = st.count_zero ? S_FINISH : S_BACK;
              end else if (!st.count_full) begin
                cmd.count_inc = 1'b1;
                prompt_next   = PROMPT_NONE;
                state_next    = S_PLACE;
              end else begin
                state_next = S_FINISH;
              end
            end
            MODE_PRINT: begin
              prompt_next = PROMPT_NONE;
              state_next  = st.ch_lf ? S_NEWLINE : S_PLACE;
            end
            MODE_READ: begin
              state_next = S_READ;
            end
            default: begin
              cmd.home       = 1'b1;
              cmd.sweep_clr  = 1'b1;
              from_item_next = 1'b1;
              state_next     = S_CLEAR;
            end
          endcase
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        case (prompt)
          PROMPT_DOLLAR: cmd.char_sel = SEL_DOLLAR;
          PROMPT_SPACE:  cmd.char_sel = SEL_SPACE;
          default:       cmd.char_sel = SEL_ITEM;
        endcase
        prompt_next = prompt_dec;
        if (st.col_wrap) begin
          state_next = S_NEWLINE;
        end else if (prompt_dec != PROMPT_NONE) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_NEWLINE: begin
        cmd.newline = 1'b1;
        if (st.row_bottom) begin
          cmd.sweep_clr = 1'b1;
          state_next    = S_SCROLL;
        end else begin
          state_next = (prompt != PROMPT_NONE) ? S_PLACE : S_FINISH;
        end
      end
      S_SCROLL: begin
        cmd.scroll_wr = 1'b1;
        if (st.row_done) begin
          state_next = (prompt != PROMPT_NONE) ? S_PLACE : S_FINISH;
        end
      end
      S_BACK: begin
        cmd.back   = 1'b1;
        state_next = S_BLANK;
      end
      S_BLANK: begin
        cmd.blank  = 1'b1;
        state_next = S_FINISH;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_READW;
      end
      S_READW: begin
        cmd.capture = 1'b1;
        state_next  = S_FINISH;
      end
      S_CLEAR: begin
        cmd.fill_wr = 1'b1;
        if (st.fill_done) begin
          from_item_next = 1'b0;
          state_next     = from_item ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      prompt    <= PROMPT_NONE;
      from_item <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      prompt    <= prompt_next;
      from_item <= from_item_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/tcgle_dp.sv @@
// Datapath of the text console grid line editor: cursor, line count, row offset,
// sweep counter, the cell RAM and the result register; depends on tcgle_pkg and tcgle_ram.
module tcgle_dp #(
  parameter int COLS = 40,
  parameter int ROWS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            char_code,
  input  logic [3:0]            row_index,
  input  logic [5:0]            col_index,
  input  tcgle_pkg::dp_cmd_t    cmd,
  output tcgle_pkg::dp_status_t st,
  output logic [7:0]            cell_char,
  output logic [3:0]            cursor_row,
  output logic [5:0]            cursor_col,
  output logic [5:0]            edit_length
);
  import tcgle_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);
  localparam logic [CW:0]   COLS_X   = (CW + 1)'(COLS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
  localparam logic [AW-1:0] COLS_A   = AW'(COLS);
  localparam logic [AW-1:0] ROW_END  = AW'(COLS - 1);
  localparam logic [AW-1:0] FILL_END = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] cell_at(input logic [RW-1:0] off,
                                            input logic [RW-1:0] vrow,
                                            input logic [CW-1:0] col);
    logic [RW:0]   sum;
    logic [RW-1:0] prow;
    sum = {1'b0, off} + {1'b0, vrow};
    if (sum >= ROWS_X) begin
      prow = RW'(sum - ROWS_X);
    end else begin
      prow = sum[RW-1:0];
    end
    return AW'(prow) * COLS_A + AW'(col);
  endfunction

  logic [RW-1:0] offset, offset_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] sweep, sweep_next;
  logic [7:0]    ch_q;
  logic [3:0]    row_q;
  logic [5:0]    col_q;
  logic [7:0]    read_char;

  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [RW:0]   off_inc;
  logic          in_range;
  logic [7:0]    place_char;
  logic [RW-1:0] wvrow;
  logic [CW-1:0] wcol;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  assign col_inc  = {1'b0, cur_col} + 1'b1;
  assign row_inc  = {1'b0, cur_row} + 1'b1;
  assign off_inc  = {1'b0, offset} + 1'b1;
  assign in_range = (32'(row_q) < ROWS) && (32'(col_q) < COLS);

  assign st.ch_line_end = (char_code == CH_CR) || (char_code == CH_LF);
  assign st.ch_lf       = (char_code == CH_LF);
  assign st.ch_bs       = (char_code == CH_BS);
  assign st.count_zero  = (count == '0);
  assign st.count_full  = (count == COL_LAST);
  assign st.col_wrap    = (col_inc == COLS_X);
  assign st.row_bottom  = (row_inc == ROWS_X);
  assign st.row_done    = (sweep == ROW_END);
  assign st.fill_done   = (sweep == FILL_END);

  always_comb begin
    case (cmd.char_sel)
      SEL_ITEM:   place_char = ch_q;
      SEL_DOLLAR: place_char = CH_DOLLAR;
      SEL_SPACE:  place_char = CH_SPACE;
      default:    place_char = CH_SPACE;
    endcase
  end

  assign wvrow = cmd.scroll_wr ? ROW_LAST : cur_row;
  assign wcol  = cmd.scroll_wr ? CW'(sweep) : cur_col;
  assign we    = cmd.place || cmd.scroll_wr || cmd.fill_wr || cmd.blank;
  assign waddr = cmd.fill_wr ? sweep : cell_at(offset, wvrow, wcol);
  assign wdata = cmd.place ? place_char : CH_SPACE;
  assign raddr = in_range ? cell_at(offset, RW'(row_q), CW'(col_q)) : '0;

  tcgle_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.read),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    offset_next  = offset;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    count_next   = count;
    sweep_next   = sweep;
    if (cmd.count_clear) begin
      count_next = '0;
    end
    if (cmd.count_inc) begin
      count_next = count + 1'b1;
    end
    if (cmd.place && !st.col_wrap) begin
      cur_col_next = col_inc[CW-1:0];
    end
    if (cmd.newline) begin
      cur_col_next = '0;
      if (st.row_bottom) begin
        cur_row_next = ROW_LAST;
        offset_next  = (off_inc == ROWS_X) ? '0 : off_inc[RW-1:0];
      end else begin
        cur_row_next = row_inc[RW-1:0];
      end
    end
    if (cmd.back) begin
      count_next = count - 1'b1;
      if (cur_col != '0) begin
        cur_col_next = cur_col - 1'b1;
      end else begin
        cur_col_next = COL_LAST;
        if (cur_row != '0) begin
          cur_row_next = cur_row - 1'b1;
        end
      end
    end
    if (cmd.home) begin
      offset_next  = '0;
      cur_row_next = '0;
      cur_col_next = '0;
    end
    if (cmd.sweep_clr) begin
      sweep_next = '0;
    end else if (cmd.scroll_wr || cmd.fill_wr) begin
      sweep_next = sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset  <= '0;
      cur_row <= '0;
      cur_col <= '0;
      count   <= '0;
      sweep   <= '0;
    end else begin
      offset  <= offset_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      count   <= count_next;
      sweep   <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_q      <= char_code;
      row_q     <= row_index;
      col_q     <= col_index;
      read_char <= '0;
    end else if (cmd.capture) begin
      read_char <= in_range ? rdata : '0;
    end
    if (cmd.out_load) begin
      cell_char   <= read_char;
      cursor_row  <= 4'(cur_row);
      cursor_col  <= 6'(cur_col);
      edit_length <= 6'(count);
    end
  end

endmodule

@@ hw/rtl/text_console_grid_line_editor.sv @@
// A keystroke or printed character may break the line and scroll the grid before its result;
// a read passes through S_READ and S_READW; a clear writes every one of the ROWS*COLS cells.
// One request at a time: in_ready is high only while the controller is idle.
// Reset is synchronous; afterwards a clearing pass blanks the RAM
// while in_ready stays low. Depends on tcgle_pkg, tcgle_ctrl and tcgle_dp.
module text_console_grid_line_editor #(
  parameter int COLS = 40,
  parameter int ROWS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] char_code,
  input  logic [3:0] row_index,
  input  logic [5:0] col_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cell_char,
  output logic [3:0] cursor_row,
  output logic [5:0] cursor_col,
  output logic [5:0] edit_length
);
  import tcgle_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  tcgle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode_t'(mode)),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcgle_dp #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .row_index  (row_index),
    .col_index  (col_index),
    .cmd        (cmd),
    .st         (st),
    .cell_char  (cell_char),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .edit_length(edit_length)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Second request taken while one is in progress.");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((32'(cursor_col) < COLS) && (32'(edit_length) < COLS)))
    else $error("Cursor column or line length out of range.");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_row) < ROWS))
    else $error("Cursor row out of range.");
`endif

endmodule
